FILE: rtl/core/cct_pkg.sv
`timescale 1ns / 1ps
// Package for the calendar clock: field widths, request codes and reset values.
// No dependencies; used by the channel interfaces and the top level.

package cct_pkg;

  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  // Request codes carried in req_type.
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_type_t;

  localparam logic [YEAR_W-1:0]   RST_YEAR   = YEAR_W'(2018);
  localparam logic [MONTH_W-1:0]  RST_MONTH  = MONTH_W'(1);
  localparam logic [DAY_W-1:0]    RST_DAY    = DAY_W'(1);
  localparam logic [HOUR_W-1:0]   RST_HOUR   = '0;
  localparam logic [MINUTE_W-1:0] RST_MINUTE = '0;
  localparam logic [SECOND_W-1:0] RST_SECOND = '0;

endpackage

FILE: rtl/core/cct_in_if.sv
`timescale 1ns / 1ps
// Request channel of the calendar clock: valid/ready plus the request fields.
// Depends on cct_pkg for the field widths.

interface cct_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [cct_pkg::YEAR_W-1:0]     load_year;
  logic [cct_pkg::MONTH_W-1:0]    load_month;
  logic [cct_pkg::DAY_W-1:0]      load_day;
  logic [cct_pkg::HOUR_W-1:0]     load_hour;
  logic [cct_pkg::MINUTE_W-1:0]   load_minute;
  logic [cct_pkg::SECOND_W-1:0]   load_second;

  modport source (
    output valid, req_type, load_year, load_month, load_day,
           load_hour, load_minute, load_second,
    input  ready
  );

  modport sink (
    input  valid, req_type, load_year, load_month, load_day,
           load_hour, load_minute, load_second,
    output ready
  );
endinterface

FILE: rtl/core/cct_out_if.sv
`timescale 1ns / 1ps
// Result channel of the calendar clock: valid/ready plus the current date and time.
// Depends on cct_pkg for the field widths.

interface cct_out_if;
  logic                           valid;
  logic                           ready;
  logic [cct_pkg::YEAR_W-1:0]     cur_year;
  logic [cct_pkg::MONTH_W-1:0]    cur_month;
  logic [cct_pkg::DAY_W-1:0]      cur_day;
  logic [cct_pkg::HOUR_W-1:0]     cur_hour;
  logic [cct_pkg::MINUTE_W-1:0]   cur_minute;
  logic [cct_pkg::SECOND_W-1:0]   cur_second;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    input  ready
  );

  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    output ready
  );
endinterface

FILE: rtl/core/calendar_clock_tick.sv
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle; the date/time registers double as the
// result register, and a new request is taken whenever the result slot is
// empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): 2018-01-01 00:00:00, no result pending.
// Depends on cct_pkg, cct_in_if and cct_out_if.

module calendar_clock_tick (
  input  logic      clk,
  input  logic      rst_n,
  cct_in_if.sink    in_chan,
  cct_out_if.source out_chan
);

  localparam int unsigned YW = cct_pkg::YEAR_W;

  // Divisibility by 25 through the inverse of 25 modulo 2^16: a 16-bit value
  // is a multiple of 25 exactly when its product with the inverse, kept to
  // 16 bits, does not exceed (2^16 - 1) / 25.
  localparam logic [YW-1:0] INV25     = YW'(23593);
  localparam logic [YW-1:0] DIV25_MAX = YW'((2**YW - 1) / 25);
  localparam logic [YW-1:0] YEAR_MAX  = '1;

  localparam logic [cct_pkg::MONTH_W-1:0] MON_FEB = cct_pkg::MONTH_W'(2);
  localparam logic [cct_pkg::MONTH_W-1:0] MON_APR = cct_pkg::MONTH_W'(4);
  localparam logic [cct_pkg::MONTH_W-1:0] MON_JUN = cct_pkg::MONTH_W'(6);
  localparam logic [cct_pkg::MONTH_W-1:0] MON_SEP = cct_pkg::MONTH_W'(9);
  localparam logic [cct_pkg::MONTH_W-1:0] MON_NOV = cct_pkg::MONTH_W'(11);

  logic [YW-1:0]                    year_r,   year_nxt;
  logic [cct_pkg::MONTH_W-1:0]      month_r,  month_nxt;
  logic [cct_pkg::DAY_W-1:0]        day_r,    day_nxt;
  logic [cct_pkg::HOUR_W-1:0]       hour_r,   hour_nxt;
  logic [cct_pkg::MINUTE_W-1:0]     minute_r, minute_nxt;
  logic [cct_pkg::SECOND_W-1:0]     second_r, second_nxt;
  logic                             out_valid_r, out_valid_nxt;

  logic                             in_fire;
  logic [YW-1:0]                    div_prod;
  logic                             div25;
  logic                             leap;
  logic [cct_pkg::DAY_W-1:0]        month_len;

  // One extra bit on each stage but the year so the carry-in cannot wrap; the year saturates.
  logic [cct_pkg::SECOND_W:0]       s_t;
  logic [cct_pkg::MINUTE_W:0]       mi_t;
  logic [cct_pkg::HOUR_W:0]         h_t;
  logic [cct_pkg::DAY_W:0]          d_t;
  logic [cct_pkg::MONTH_W:0]        mo_t;
  logic [YW-1:0]                    y_t;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Gregorian rule: leap when divisible by 4, except centuries not divisible by 400.
  // With y % 4 == 0, a century is a multiple of 25, and 400 | y needs y % 16 == 0.
  assign div_prod = YW'(year_r * INV25);
  assign div25    = (div_prod <= DIV25_MAX);
  assign leap     = (year_r[1:0] == 2'b00) && !(div25 && (year_r[3:2] != 2'b00));

  always_comb begin
    case (month_r)
      MON_FEB: month_len = leap ? cct_pkg::DAY_W'(29) : cct_pkg::DAY_W'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: month_len = cct_pkg::DAY_W'(30);
      default: month_len = cct_pkg::DAY_W'(31);
    endcase
  end

  // One-second advance; each stage is checked on its own, as loaded values above
  // their range roll over even without an incoming carry.
  always_comb begin
    s_t  = {1'b0, second_r} + 1'b1;
    mi_t = {1'b0, minute_r};
    h_t  = {1'b0, hour_r};
    d_t  = {1'b0, day_r};
    mo_t = {1'b0, month_r};
    y_t  = year_r;
    if (s_t > (cct_pkg::SECOND_W+1)'(59)) begin
      s_t  = '0;
      mi_t = mi_t + 1'b1;
    end
    if (mi_t > (cct_pkg::MINUTE_W+1)'(59)) begin
      mi_t = '0;
      h_t  = h_t + 1'b1;
    end
    if (h_t > (cct_pkg::HOUR_W+1)'(23)) begin
      h_t = '0;
      d_t = d_t + 1'b1;
    end
    if (d_t > {1'b0, month_len}) begin
      d_t  = (cct_pkg::DAY_W+1)'(1);
      mo_t = mo_t + 1'b1;
    end
    if (mo_t > (cct_pkg::MONTH_W+1)'(12)) begin
      mo_t = (cct_pkg::MONTH_W+1)'(1);
      if (year_r != YEAR_MAX) begin
        y_t = year_r + 1'b1;
      end
    end
  end

  always_comb begin
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (in_chan.req_type == cct_pkg::REQ_LOAD) begin
        year_nxt   = in_chan.load_year;
        month_nxt  = in_chan.load_month;
        day_nxt    = in_chan.load_day;
        hour_nxt   = in_chan.load_hour;
        minute_nxt = in_chan.load_minute;
        second_nxt = in_chan.load_second;
      end else begin
        year_nxt   = y_t;
        month_nxt  = mo_t[cct_pkg::MONTH_W-1:0];
        day_nxt    = d_t[cct_pkg::DAY_W-1:0];
        hour_nxt   = h_t[cct_pkg::HOUR_W-1:0];
        minute_nxt = mi_t[cct_pkg::MINUTE_W-1:0];
        second_nxt = s_t[cct_pkg::SECOND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= cct_pkg::RST_YEAR;
      month_r     <= cct_pkg::RST_MONTH;
      day_r       <= cct_pkg::RST_DAY;
      hour_r      <= cct_pkg::RST_HOUR;
      minute_r    <= cct_pkg::RST_MINUTE;
      second_r    <= cct_pkg::RST_SECOND;
      out_valid_r <= 1'b0;
    end else begin
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The clock registers hold the state after the last accepted request,
  // which is exactly the pending result beat.
  assign out_chan.valid      = out_valid_r;
  assign out_chan.cur_year   = year_r;
  assign out_chan.cur_month  = month_r;
  assign out_chan.cur_day    = day_r;
  assign out_chan.cur_hour   = hour_r;
  assign out_chan.cur_minute = minute_r;
  assign out_chan.cur_second = second_r;

endmodule

FILE: tb/calendar_clock_tick_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_clock_tick: drives tick and load beats,
// predicts the date and time after each one and checks every result beat.
// Depends on cct_pkg, cct_in_if, cct_out_if and the calendar_clock_tick RTL.

module calendar_clock_tick_tb;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 550;
  localparam int unsigned HOLD_LEN         = 300;
  localparam int unsigned MAX_PRINTED      = 100;
  localparam int unsigned YEAR_TOP         = 65535;

  typedef struct packed {
    logic [cct_pkg::YEAR_W-1:0]   year;
    logic [cct_pkg::MONTH_W-1:0]  month;
    logic [cct_pkg::DAY_W-1:0]    day;
    logic [cct_pkg::HOUR_W-1:0]   hour;
    logic [cct_pkg::MINUTE_W-1:0] minute;
    logic [cct_pkg::SECOND_W-1:0] second;
  } clock_t;

  typedef struct packed {
    cct_pkg::req_type_t kind;
    clock_t             load;
  } request_t;

  logic clk;
  logic rst_n;

  cct_in_if  req_chan ();
  cct_out_if res_chan ();

  calendar_clock_tick DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  request_t    pending_reqs[$];
  clock_t      expected_times[$];
  clock_t      clock_model;
  request_t    next_req;
  request_t    taken_req;
  clock_t      got_time;
  clock_t      want_time;
  bit          in_beat;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_orders;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatch_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Invalid months (0, 13..15) count as 31-day months.
  function automatic int unsigned days_in_month(int unsigned mo, int unsigned y);
    if (mo == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Each stage is tested on its own, so a field loaded above its range rolls over
  // even without an incoming carry.
  function automatic clock_t advance_clock(clock_t now, request_t rq);
    clock_t      nx;
    int unsigned s;
    int unsigned mi;
    int unsigned h;
    int unsigned d;
    int unsigned mo;
    int unsigned y;
    if (rq.kind == cct_pkg::REQ_LOAD) begin
      return rq.load;
    end
    s  = now.second + 1;
    mi = now.minute;
    h  = now.hour;
    d  = now.day;
    mo = now.month;
    y  = now.year;
    if (s > 59) begin
      s  = 0;
      mi = mi + 1;
    end
    if (mi > 59) begin
      mi = 0;
      h  = h + 1;
    end
    if (h > 23) begin
      h = 0;
      d = d + 1;
    end
    if (d > days_in_month(mo, y)) begin
      d  = 1;
      mo = mo + 1;
    end
    if (mo > 12) begin
      mo = 1;
      if (y < YEAR_TOP) begin
        y = y + 1;
      end
    end
    nx.year   = cct_pkg::YEAR_W'(y);
    nx.month  = cct_pkg::MONTH_W'(mo);
    nx.day    = cct_pkg::DAY_W'(d);
    nx.hour   = cct_pkg::HOUR_W'(h);
    nx.minute = cct_pkg::MINUTE_W'(mi);
    nx.second = cct_pkg::SECOND_W'(s);
    return nx;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic queue_load(int unsigned y, int unsigned mo, int unsigned d,
                            int unsigned h, int unsigned mi, int unsigned s);
    request_t rq;
    rq.kind        = cct_pkg::REQ_LOAD;
    rq.load.year   = cct_pkg::YEAR_W'(y);
    rq.load.month  = cct_pkg::MONTH_W'(mo);
    rq.load.day    = cct_pkg::DAY_W'(d);
    rq.load.hour   = cct_pkg::HOUR_W'(h);
    rq.load.minute = cct_pkg::MINUTE_W'(mi);
    rq.load.second = cct_pkg::SECOND_W'(s);
    pending_reqs.push_back(rq);
  endtask

  // The load fields of a tick are don't-care, so they get random junk.
  task automatic queue_tick();
    request_t rq;
    rq.load = clock_t'({$urandom, $urandom});
    rq.kind = cct_pkg::REQ_TICK;
    pending_reqs.push_back(rq);
  endtask

  // One random run: mostly a load just short of a rollover followed by a few
  // ticks, sometimes a full-width junk load, sometimes a plain run of ticks.
  task automatic queue_random_run(output int unsigned count);
    int unsigned choice;
    int unsigned y;
    int unsigned mo;
    int unsigned d;
    int unsigned len;
    int unsigned h;
    int unsigned mi;
    int unsigned s;
    int unsigned n;
    choice = $urandom_range(99);
    count  = 0;
    if (choice < 70) begin
      case ($urandom_range(5))
        0: y = $urandom_range(YEAR_TOP, 0);
        1: y = $urandom_range(163, 0) * 400;
        2: y = $urandom_range(655, 0) * 100;
        3: y = $urandom_range(16383, 0) * 4;
        4: y = YEAR_TOP;
        default: y = $urandom_range(2100, 1896);
      endcase
      mo  = $urandom_range(12, 1);
      len = days_in_month(mo, y);
      case ($urandom_range(7))
        0: d = len - 1;
        1: d = $urandom_range(len, 1);
        2: d = len + 1;
        default: d = len;
      endcase
      if ($urandom_range(99) < 60) begin
        h  = 23;
        mi = 59;
        s  = $urandom_range(59, 57);
      end else begin
        h  = $urandom_range(23, 0);
        mi = $urandom_range(59, 0);
        s  = $urandom_range(59, 0);
      end
      queue_load(y, mo, d, h, mi, s);
      n = $urandom_range(6, 1);
    end else if (choice < 85) begin
      queue_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      n = $urandom_range(3, 1);
    end else begin
      n = $urandom_range(8, 1);
      count = 0;
    end
    if (choice < 85) begin
      count = 1;
    end
    repeat (n) begin
      queue_tick();
    end
    count = count + n;
  endtask

  task automatic wait_until_drained();
    while (!(pending_reqs.size() == 0 && expected_times.size() == 0 && !req_chan.valid)) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Sender: a new beat is offered once the previous one has been taken.
  always @(negedge clk) begin
    if (rst_n && (!req_chan.valid || in_beat)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req             = pending_reqs.pop_front();
        req_chan.req_type    <= next_req.kind;
        req_chan.load_year   <= next_req.load.year;
        req_chan.load_month  <= next_req.load.month;
        req_chan.load_day    <= next_req.load.day;
        req_chan.load_hour   <= next_req.load.hour;
        req_chan.load_minute <= next_req.load.minute;
        req_chan.load_second <= next_req.load.second;
        req_chan.valid       <= 1'b1;
      end else begin
        req_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_served != hold_orders) begin
      hold_served    <= hold_served + 1;
      hold_left      <= HOLD_LEN;
      res_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      res_chan.ready <= 1'b0;
    end else begin
      res_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks result beats and feeds the predictor with request beats.
  always @(posedge clk) begin
    in_beat = rst_n && req_chan.valid && req_chan.ready;
    if (rst_n && res_chan.valid && res_chan.ready) begin
      got_time = '{res_chan.cur_year, res_chan.cur_month, res_chan.cur_day,
                   res_chan.cur_hour, res_chan.cur_minute, res_chan.cur_second};
      if (expected_times.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with nothing expected",
                                  got_time.year, got_time.month, got_time.day,
                                  got_time.hour, got_time.minute, got_time.second));
      end else begin
        want_time = expected_times.pop_front();
        compare_field("year", got_time.year, want_time.year);
        compare_field("month", got_time.month, want_time.month);
        compare_field("day", got_time.day, want_time.day);
        compare_field("hour", got_time.hour, want_time.hour);
        compare_field("minute", got_time.minute, want_time.minute);
        compare_field("second", got_time.second, want_time.second);
      end
    end
    if (in_beat) begin
      taken_req.kind = cct_pkg::req_type_t'(req_chan.req_type);
      taken_req.load = '{req_chan.load_year, req_chan.load_month, req_chan.load_day,
                         req_chan.load_hour, req_chan.load_minute, req_chan.load_second};
      clock_model = advance_clock(clock_model, taken_req);
      expected_times.push_back(clock_model);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned queued;
    int unsigned run_len;
    rst_n                = 1'b0;
    req_chan.valid       = 1'b0;
    req_chan.req_type    = cct_pkg::REQ_TICK;
    req_chan.load_year   = '0;
    req_chan.load_month  = '0;
    req_chan.load_day    = '0;
    req_chan.load_hour   = '0;
    req_chan.load_minute = '0;
    req_chan.load_second = '0;
    res_chan.ready       = 1'b0;
    in_beat              = 1'b0;
    hold_orders          = 0;
    hold_served          = 0;
    hold_left            = 0;
    cycle_count          = 0;
    mismatch_count       = 0;
    send_idle_pct        = 33;
    recv_idle_pct        = 76;
    clock_model          = '{cct_pkg::RST_YEAR, cct_pkg::RST_MONTH, cct_pkg::RST_DAY,
                             cct_pkg::RST_HOUR, cct_pkg::RST_MINUTE, cct_pkg::RST_SECOND};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: plain tick from reset, year end, leap rules, the year
    // ceiling, all-ones and all-zeros loads, and out-of-range loaded fields.
    queue_tick();
    queue_load(2023, 12, 31, 23, 59, 59);
    queue_tick();
    queue_load(2024, 2, 28, 23, 59, 59);
    queue_tick();
    queue_load(2024, 2, 29, 23, 59, 59);
    queue_tick();
    queue_load(1900, 2, 28, 23, 59, 59);
    queue_tick();
    queue_load(2000, 2, 28, 23, 59, 59);
    queue_tick();
    queue_load(65535, 12, 31, 23, 59, 59);
    queue_tick();
    queue_load(65535, 15, 31, 31, 63, 63);
    queue_tick();
    queue_load(0, 0, 0, 0, 0, 0);
    queue_tick();
    queue_load(2021, 3, 0, 23, 59, 59);
    queue_tick();
    queue_load(2021, 0, 31, 23, 59, 59);
    queue_tick();
    queue_load(2021, 4, 31, 5, 61, 10);
    queue_tick();
    queue_load(2021, 13, 10, 25, 0, 0);
    queue_tick();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queued = 0;
      while (queued < RANDOM_PER_PHASE) begin
        queue_random_run(run_len);
        queued = queued + run_len;
      end
      // With the sender never idle, a long receiver hold-off backs up the
      // single result slot and must stall the request side.
      if (phase == 2) begin
        hold_orders = hold_orders + 1;
      end
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
